/* hw/rtl/rebd_pkg.sv */
`timescale 1ns / 1ps

package rebd_pkg;

  // millisecond clock width, time differences wrap at this width
  localparam int TIME_W = 32;
  localparam int LONG_W = 16;
  localparam int DEB_W  = 8;
  localparam int POS_W  = 32;
  localparam int CMP_W  = (TIME_W > LONG_W) ? TIME_W : LONG_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [1:0]        op_t;
  typedef logic [1:0]        evt_t;

  localparam op_t OP_SAMPLE = 2'd0;
  localparam op_t OP_LOAD   = 2'd1;
  localparam op_t OP_TAKE   = 2'd2;

  localparam evt_t EVT_NONE  = 2'd0;
  localparam evt_t EVT_SHORT = 2'd1;
  localparam evt_t EVT_LONG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENC_DEB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_DEB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 2'd2;

  localparam logic [DEB_W-1:0]  ENC_DEB_RST = 8'd2;
  localparam logic [DEB_W-1:0]  BTN_DEB_RST = 8'd20;
  localparam logic [LONG_W-1:0] LONG_RST    = 16'd800;

  // per-beat strobes from the input stage to the state units
  typedef struct packed {
    logic sample;
    logic load;
    logic take;
  } rebd_ctrl_t;

  typedef struct packed {
    evt_t event_code;
    logic level;
  } rebd_btn_stat_t;

endpackage

/* hw/rtl/rebd_encoder.sv */
`timescale 1ns / 1ps

module rebd_encoder
  import rebd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  rebd_ctrl_t              ctrl,
  input  logic                    pin_a,
  input  logic                    pin_b,
  input  logic signed [POS_W-1:0] load_value,
  input  time_t                   now,
  input  logic [DEB_W-1:0]        debounce_ms,
  output logic signed [POS_W-1:0] position_nxt
);

  logic                    last_a_r, last_a_nxt;
  logic                    last_b_r, last_b_nxt;
  time_t                   stamp_r, stamp_nxt;
  logic signed [POS_W-1:0] pos_r;
  time_t                   elapsed;

  assign elapsed = now - stamp_r;

  always_comb begin
    last_a_nxt   = last_a_r;
    last_b_nxt   = last_b_r;
    stamp_nxt    = stamp_r;
    position_nxt = pos_r;
    if (ctrl.sample) begin
      if ((pin_a != last_a_r) || (pin_b != last_b_r)) begin
        if (CMP_W'(elapsed) >= CMP_W'(debounce_ms)) begin
          // count on falling edge of phase a, direction from phase b
          if (last_a_r && !pin_a) begin
            if (pin_b) begin
              position_nxt = pos_r + POS_W'(1);
            end else begin
              position_nxt = pos_r - POS_W'(1);
            end
          end
          last_a_nxt = pin_a;
          last_b_nxt = pin_b;
          stamp_nxt  = now;
        end
      end else begin
        stamp_nxt = now;
      end
    end else if (ctrl.load) begin
      position_nxt = load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r <= 1'b1;
      last_b_r <= 1'b1;
      stamp_r  <= '0;
      pos_r    <= '0;
    end else begin
      last_a_r <= last_a_nxt;
      last_b_r <= last_b_nxt;
      stamp_r  <= stamp_nxt;
      pos_r    <= position_nxt;
    end
  end

endmodule

/* hw/rtl/rebd_button.sv */
`timescale 1ns / 1ps

module rebd_button
  import rebd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rebd_ctrl_t        ctrl,
  input  logic              pin_push,
  input  time_t             now,
  input  logic [DEB_W-1:0]  debounce_ms,
  input  logic [LONG_W-1:0] long_press_ms,
  output rebd_btn_stat_t    stat
);

  logic  key_r, key_nxt;
  time_t press_stamp_r, press_stamp_nxt;
  evt_t  pending_r, pending_nxt;
  logic  fired_r, fired_nxt;
  evt_t  evt_pre;
  time_t held;

  assign held = now - press_stamp_r;

  always_comb begin
    key_nxt         = key_r;
    press_stamp_nxt = press_stamp_r;
    evt_pre         = pending_r;
    fired_nxt       = fired_r;
    if (ctrl.sample) begin
      if (pin_push != key_r) begin
        if (CMP_W'(held) > CMP_W'(debounce_ms)) begin
          key_nxt   = pin_push;
          fired_nxt = 1'b0;
          if (!pin_push) begin
            press_stamp_nxt = now;
          end else if (CMP_W'(held) < CMP_W'(long_press_ms)) begin
            evt_pre = EVT_SHORT;
          end
        end
      end else if (!pin_push) begin
        // one long event per press
        if ((CMP_W'(held) >= CMP_W'(long_press_ms)) && !fired_r) begin
          evt_pre   = EVT_LONG;
          fired_nxt = 1'b1;
        end
      end
    end
    pending_nxt = ctrl.take ? EVT_NONE : evt_pre;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r         <= 1'b1;
      press_stamp_r <= '0;
      pending_r     <= EVT_NONE;
      fired_r       <= 1'b0;
    end else begin
      key_r         <= key_nxt;
      press_stamp_r <= press_stamp_nxt;
      pending_r     <= pending_nxt;
      fired_r       <= fired_nxt;
    end
  end

  assign stat.event_code = evt_pre;
  assign stat.level      = key_nxt;

endmodule

/* hw/rtl/rotary_encoder_button_decoder_top.sv */
`timescale 1ns / 1ps

// Quadrature knob and push button decoder. Every accepted beat gives exactly one
// result beat. A beat is registered in the input register and is then decoded
// against the held state into the result register, so the block takes one beat
// per clock when out_stall stays low. Sample beats advance the millisecond clock
// by one, so the host is expected to send one per ms. The user must write
// configuration through cfg_we/cfg_index/cfg_wdata only while no beat is in
// flight; the block itself does not enforce this.
module rotary_encoder_button_decoder_top
  import rebd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_operation,
  input  logic                         in_pin_a,
  input  logic                         in_pin_b,
  input  logic                         in_pin_push,
  input  logic signed [POS_W-1:0]      in_load_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [POS_W-1:0]      out_position,
  output logic [1:0]                   out_event_code,
  output logic                         out_button_level,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  logic [DEB_W-1:0]  enc_deb_r;
  logic [DEB_W-1:0]  btn_deb_r;
  logic [LONG_W-1:0] long_r;

  logic                    stg_valid_r;
  op_t                     stg_op_r;
  logic                    stg_a_r;
  logic                    stg_b_r;
  logic                    stg_push_r;
  logic signed [POS_W-1:0] stg_load_r;

  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_r;
  evt_t                    out_evt_r;
  logic                    out_lvl_r;

  time_t                   time_r;
  time_t                   now;
  logic                    out_free;
  logic                    fire;
  rebd_ctrl_t              ctrl;
  logic signed [POS_W-1:0] pos_nxt;
  rebd_btn_stat_t          btn_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_deb_r <= ENC_DEB_RST;
      btn_deb_r <= BTN_DEB_RST;
      long_r    <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENC_DEB: enc_deb_r <= cfg_wdata[DEB_W-1:0];
        CFG_BTN_DEB: btn_deb_r <= cfg_wdata[DEB_W-1:0];
        CFG_LONG:    long_r    <= cfg_wdata[LONG_W-1:0];
        default:     ;
      endcase
    end
  end

  // input stage moves on when the result register is empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = stg_valid_r && out_free;
  assign in_stall = stg_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_op_r   <= in_operation;
      stg_a_r    <= in_pin_a;
      stg_b_r    <= in_pin_b;
      stg_push_r <= in_pin_push;
      stg_load_r <= in_load_value;
    end
  end

  assign ctrl.sample = fire && (stg_op_r == OP_SAMPLE);
  assign ctrl.load   = fire && (stg_op_r == OP_LOAD);
  assign ctrl.take   = fire && (stg_op_r == OP_TAKE);

  assign now = time_r + TIME_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (ctrl.sample) begin
      time_r <= now;
    end
  end

  rebd_encoder u_encoder (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .pin_a        (stg_a_r),
    .pin_b        (stg_b_r),
    .load_value   (stg_load_r),
    .now          (now),
    .debounce_ms  (enc_deb_r),
    .position_nxt (pos_nxt)
  );

  rebd_button u_button (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .pin_push      (stg_push_r),
    .now           (now),
    .debounce_ms   (btn_deb_r),
    .long_press_ms (long_r),
    .stat          (btn_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pos_r <= pos_nxt;
      out_evt_r <= btn_stat.event_code;
      out_lvl_r <= btn_stat.level;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_pos_r;
  assign out_event_code   = out_evt_r;
  assign out_button_level = out_lvl_r;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rebd_pkg::*;

  // operation code 3 is not used by the block and register index 3 is not mapped
  localparam op_t                  OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic signed [POS_W-1:0] position;
    evt_t                    event_code;
    logic                    level;
  } knob_readout_t;

  logic                    clk;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_operation     = OP_SAMPLE;
  logic                    in_pin_a         = 1'b1;
  logic                    in_pin_b         = 1'b1;
  logic                    in_pin_push      = 1'b1;
  logic signed [POS_W-1:0] in_load_value    = '0;
  logic                    out_valid;
  logic                    out_stall        = 1'b0;
  logic signed [POS_W-1:0] out_position;
  logic [1:0]              out_event_code;
  logic                    out_button_level;
  logic                    cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index        = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata        = '0;

  // knob state as the block should hold it
  logic [DEB_W-1:0]        enc_deb_ms;
  logic [DEB_W-1:0]        btn_deb_ms;
  logic [LONG_W-1:0]       long_ms;
  time_t                   now_ms;
  logic                    last_a;
  logic                    last_b;
  time_t                   enc_mark;
  logic signed [POS_W-1:0] knob_pos;
  logic                    key_lvl;
  time_t                   press_mark;
  evt_t                    pending_evt;
  logic                    long_done;

  knob_readout_t           readouts_due[$];
  knob_readout_t           want;
  int                      readouts_seen;
  int                      mismatch_count;
  int                      stall_left;
  int                      hold_request;
  bit                      quiet_mode;

  rotary_encoder_button_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_pin_a         (in_pin_a),
    .in_pin_b         (in_pin_b),
    .in_pin_push      (in_pin_push),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_event_code   (out_event_code),
    .out_button_level (out_button_level),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for result beats");
    $display("Mismatches found");
    $finish;
  end

  function void reset_knob_model();
    enc_deb_ms  = ENC_DEB_RST;
    btn_deb_ms  = BTN_DEB_RST;
    long_ms     = LONG_RST;
    now_ms      = '0;
    last_a      = 1'b1;
    last_b      = 1'b1;
    enc_mark    = '0;
    knob_pos    = '0;
    key_lvl     = 1'b1;
    press_mark  = '0;
    pending_evt = EVT_NONE;
    long_done   = 1'b0;
  endfunction

  function void predict_readout(op_t op, logic a, logic b, logic push,
                                logic signed [POS_W-1:0] load);
    time_t         since_enc;
    time_t         held;
    knob_readout_t r;
    if (op == OP_SAMPLE) begin
      now_ms = now_ms + 1;
      since_enc = now_ms - enc_mark;
      if (a != last_a || b != last_b) begin
        if (since_enc >= enc_deb_ms) begin
          if (last_a && !a) begin
            knob_pos = b ? knob_pos + 1 : knob_pos - 1;
          end
          last_a   = a;
          last_b   = b;
          enc_mark = now_ms;
        end
      end else begin
        enc_mark = now_ms;
      end
      held = now_ms - press_mark;
      if (push != key_lvl) begin
        if (held > btn_deb_ms) begin
          key_lvl = push;
          if (!push) begin
            press_mark = now_ms;
          end else if (held < long_ms) begin
            pending_evt = EVT_SHORT;
          end
          long_done = 1'b0;
        end
      end else if (!push && held >= long_ms && !long_done) begin
        pending_evt = EVT_LONG;
        long_done   = 1'b1;
      end
    end else if (op == OP_LOAD) begin
      knob_pos = load;
    end
    r.position   = knob_pos;
    r.event_code = pending_evt;
    r.level      = key_lvl;
    if (op == OP_TAKE) begin
      pending_evt = EVT_NONE;
    end
    readouts_due.push_back(r);
  endfunction

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function logic signed [POS_W-1:0] pick_load();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function logic [1:0] quad_levels(int idx);
    case (idx)
      0:       return 2'b11;
      1:       return 2'b01;
      2:       return 2'b00;
      default: return 2'b10;
    endcase
  endfunction

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp_val);
    mismatch_count++;
    $display("%0t: %s: got %0h, wanted %0h (result beat %0d)",
             $time, what, got, exp_val, readouts_seen);
  endtask

  // receiver side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end else if (stall_left == 0 && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      readouts_seen++;
      if (readouts_due.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_position, 0);
      end else begin
        want = readouts_due.pop_front();
        if (out_position !== want.position)
          report_mismatch("position", out_position, want.position);
        if (out_event_code !== want.event_code)
          report_mismatch("event_code", 32'(out_event_code), 32'(want.event_code));
        if (out_button_level !== want.level)
          report_mismatch("button_level", 32'(out_button_level), 32'(want.level));
      end
    end
  end

  // called at a clock edge; returns at an edge after the beat is taken and any gap
  task send_beat(input op_t op, input logic a, input logic b, input logic push,
                 input logic signed [POS_W-1:0] load);
    int gap;
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_pin_a      <= a;
    in_pin_b      <= b;
    in_pin_push   <= push;
    in_load_value <= load;
    do @(posedge clk); while (in_stall);
    predict_readout(op, a, b, push, load);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (readouts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_config(input logic [DEB_W-1:0] enc, input logic [DEB_W-1:0] btn,
                    input logic [LONG_W-1:0] lng);
    wait_idle();
    // junk in the upper byte of the narrow registers must be dropped
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENC_DEB;
    cfg_wdata <= {8'($urandom), enc};
    @(posedge clk);
    enc_deb_ms = enc;
    cfg_index <= CFG_BTN_DEB;
    cfg_wdata <= {8'($urandom), btn};
    @(posedge clk);
    btn_deb_ms = btn;
    cfg_index <= CFG_LONG;
    cfg_wdata <= lng;
    @(posedge clk);
    long_ms = lng;
    cfg_index <= CFG_SPARE;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // quadrature turns and button presses with random hold times, mixed with other ops
  task automatic run_random(input int count, input int enc_hold, input int btn_hold);
    int         i;
    int         r;
    int         enc_left;
    int         btn_left;
    int         qidx;
    bit         dir_up;
    logic       push_lvl;
    logic [1:0] ab;
    op_t        op;
    logic       a;
    logic       b;
    logic       push;
    qidx     = 0;
    dir_up   = 1'b1;
    push_lvl = 1'b1;
    enc_left = 0;
    btn_left = $urandom_range(0, btn_hold);
    for (i = 0; i < count; i++) begin
      op   = OP_SAMPLE;
      a    = 1'($urandom);
      b    = 1'($urandom);
      push = 1'($urandom);
      r    = $urandom_range(0, 99);
      if (r < 78) begin
        if (enc_left == 0) begin
          if ($urandom_range(0, 4) == 0) dir_up = !dir_up;
          qidx     = dir_up ? (qidx + 1) % 4 : (qidx + 3) % 4;
          enc_left = $urandom_range(0, enc_hold);
        end else begin
          enc_left--;
        end
        if (btn_left == 0) begin
          push_lvl = !push_lvl;
          btn_left = $urandom_range(0, btn_hold);
        end else begin
          btn_left--;
        end
        ab = quad_levels(qidx);
        // now and then leave the random levels in place as contact noise
        if ($urandom_range(0, 19) != 0) {a, b} = ab;
        if ($urandom_range(0, 29) != 0) push = push_lvl;
        send_beat(op, a, b, push, $urandom);
      end else if (r < 88) begin
        send_beat(OP_TAKE, a, b, push, $urandom);
      end else if (r < 95) begin
        send_beat(OP_LOAD, a, b, push, pick_load());
      end else begin
        send_beat(OP_SPARE, a, b, push, $urandom);
      end
    end
  endtask

  // runs at reset settings: debounce of 2 ms on the encoder
  task test_position_load_and_wrap();
    send_beat(OP_LOAD, 1'b0, 1'b0, 1'b1, 32'sh7fff_ffff);
    send_beat(OP_SAMPLE, 1'b1, 1'b1, 1'b1, '0);
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 1'b1, '0);   // too early, ignored
    send_beat(OP_SAMPLE, 1'b0, 1'b1, 1'b1, '0);   // A falls with B high, wraps up
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 1'b1, '0);
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 1'b1, '0);
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 1'b1, '0);
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 1'b1, '0);
    send_beat(OP_LOAD, 1'b1, 1'b1, 1'b0, 32'sh8000_0000);
    send_beat(OP_SAMPLE, 1'b1, 1'b0, 1'b1, '0);
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 1'b1, '0);
    send_beat(OP_SAMPLE, 1'b0, 1'b0, 1'b1, '0);   // A falls with B low, wraps down
    send_beat(OP_SPARE, 1'b1, 1'b1, 1'b0, -1);
    send_beat(OP_TAKE, 1'b1, 1'b1, 1'b0, -1);
    send_beat(OP_LOAD, 1'b0, 1'b0, 1'b0, '0);
  endtask

  task test_button_press_types();
    int i;
    write_config(8'd0, 8'd1, 16'd3);
    for (i = 0; i < 5; i++) send_beat(OP_SAMPLE, 1'b1, 1'b1, 1'b0, '0);  // long, once
    send_beat(OP_SAMPLE, 1'b1, 1'b1, 1'b1, '0);
    send_beat(OP_SAMPLE, 1'b1, 1'b1, 1'b0, '0);
    send_beat(OP_SAMPLE, 1'b1, 1'b1, 1'b1, '0);   // bounce, too soon after press
    send_beat(OP_SAMPLE, 1'b1, 1'b1, 1'b1, '0);   // short overwrites pending long
    send_beat(OP_TAKE, 1'b0, 1'b0, 1'b0, '0);
    write_config(8'd0, 8'd0, 16'd0);
    for (i = 0; i < 3; i++) send_beat(OP_SAMPLE, 1'b1, 1'b1, 1'b0, '0);
    send_beat(OP_SAMPLE, 1'b1, 1'b1, 1'b1, '0);
    send_beat(OP_TAKE, 1'b1, 1'b1, 1'b1, '0);
  endtask

  task test_backpressure();
    wait_idle();
    quiet_mode   = 1'b1;
    hold_request = 80;
    run_random(40, 3, 20);
    quiet_mode = 1'b0;
    wait_idle();
  endtask

  task test_random_traffic();
    write_config(ENC_DEB_RST, BTN_DEB_RST, LONG_RST);
    run_random(140, 6, 60);
    write_config(8'd0, 8'd0, 16'd0);
    quiet_mode = 1'b1;
    run_random(110, 3, 6);
    quiet_mode = 1'b0;
    write_config(8'd255, 8'd255, 16'hffff);
    run_random(90, 10, 40);
    write_config(8'd1, 8'd3, 16'd12);
    run_random(170, 4, 30);
    write_config(8'd3, 8'd8, 16'd40);
    run_random(140, 8, 70);
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    reset_knob_model();
    @(posedge clk);
    test_position_load_and_wrap();
    test_button_press_types();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    waited = 0;
    while (readouts_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (readouts_due.size() != 0)
      report_mismatch("result beats never arrived", 0, readouts_due.size());
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rebd_pkg.sv
hw/rtl/rebd_encoder.sv
hw/rtl/rebd_button.sv
hw/rtl/rotary_encoder_button_decoder_top.sv
sim/testbench.sv
